// ===== hdl/smecr_pkg.sv =====
// Shared types and constants for the Sobel minimum-eigenvalue corner core.
// Depends on nothing; imported by the controller, datapath and top level.
package smecr_pkg;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH = 1'b0;
    localparam logic REG_THRESHOLD   = 1'b1;

    localparam int CFG_DATA_W   = 25;
    localparam int WIDTH_MIN    = 8;
    localparam int WIDTH_RESET  = 640;

    // iteration counts of the sequenced steps
    localparam int SUM_STEPS  = 5;   // taps of a gradient column, columns of the window
    localparam int MUL_STEPS  = 25;  // bits of the serial squarer
    localparam int SQRT_STEPS = 26;  // result bits of the square root
    localparam int STEP_W     = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_GRAD,
        S_COL,
        S_CSHIFT,
        S_WSUM,
        S_ABS,
        S_MUL,
        S_SINIT,
        S_SQRT,
        S_FIN
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic              accept;
        logic              read;
        logic              shift;
        logic              grad;
        logic              col_step;
        logic              cshift;
        logic              wsum_step;
        logic              abs_diff;
        logic              mul_step;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              load_out;
        logic [STEP_W-1:0] step;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic has_result;
        logic full_window;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/smecr_ctrl.sv =====
// Sequencer for one pixel item: memory read, gradient, sums, squarer, root.
// Depends on smecr_pkg; drives t_cmd into smecr_datapath.
module smecr_ctrl
    import smecr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_cmd.step = r_step;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = S_GRAD;
            end
            S_GRAD: begin
                o_cmd.grad = 1'b1;
                n_step     = '0;
                n_state    = S_COL;
            end
            S_COL: begin
                o_cmd.col_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(SUM_STEPS - 1)) begin
                    n_state = S_CSHIFT;
                end
            end
            S_CSHIFT: begin
                o_cmd.cshift = 1'b1;
                n_step       = '0;
                priority if (!i_status.has_result) begin
                    n_state = S_IDLE;
                end else if (i_status.full_window) begin
                    n_state = S_WSUM;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WSUM: begin
                o_cmd.wsum_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == STEP_W'(SUM_STEPS - 1)) begin
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                o_cmd.abs_diff = 1'b1;
                n_step         = '0;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                    n_state = S_SINIT;
                end
            end
            S_SINIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_step          = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // an accepted item always starts with the memory read
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_READ)
        else $error("accept not followed by read");

    // result register is loaded only when it can take an item
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("output loaded while occupied");

    // the root always runs its full bit count
    a_sqrt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_step == STEP_W'(SQRT_STEPS - 1)) |=> r_state == S_FIN)
        else $error("square root ended early or late");

endmodule

// ===== hdl/smecr_datapath.sv =====
// Datapath: counters, line stores, Sobel window, tensor sums, squarer, root.
// Depends on smecr_pkg; sequenced by smecr_ctrl through t_cmd.
module smecr_datapath
    import smecr_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [7:0]            i_pixel,
    input  logic                  i_frame_start,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [24:0]           o_response,
    output logic [11:0]           o_out_row,
    output logic [9:0]            o_out_col
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int WW = CW + 1;

    // configuration
    logic [10:0] r_image_width;
    logic [24:0] r_threshold;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= 11'(WIDTH_RESET);
            r_threshold   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH: r_image_width <= i_cfg_data[10:0];
                REG_THRESHOLD:   r_threshold   <= i_cfg_data[24:0];
                default:         r_threshold   <= r_threshold;
            endcase
        end
    end

    // effective width, clamped to the supported range
    logic [WW-1:0] w_eff;
    always_comb begin
        priority if (r_image_width < 11'(WIDTH_MIN)) begin
            w_eff = WW'(WIDTH_MIN);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
    end

    // raster position of the incoming item
    logic [CW-1:0] r_col_cnt, r_col;
    logic [RW-1:0] r_row_cnt, r_row;
    logic [7:0]    r_pix;
    logic [CW-1:0] cur_c;
    logic [RW-1:0] cur_r;
    logic [WW-1:0] next_c;
    always_comb begin
        cur_c = i_frame_start ? '0 : r_col_cnt;
        cur_r = i_frame_start ? '0 : r_row_cnt;
        if ({1'b0, cur_c} >= w_eff) begin
            cur_c = CW'(w_eff - 1'b1);
        end
        next_c = {1'b0, cur_c} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (i_cmd.accept) begin
            if (next_c >= w_eff) begin
                r_col_cnt <= '0;
                if (cur_r < RW'(MAX_ROWS - 1)) begin
                    r_row_cnt <= cur_r + 1'b1;
                end else begin
                    r_row_cnt <= cur_r;
                end
            end else begin
                r_col_cnt <= CW'(next_c);
                r_row_cnt <= cur_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_col <= cur_c;
            r_row <= cur_r;
            r_pix <= i_pixel;
        end
    end

    // pixel line stores: row r-1 and row r-2
    logic [7:0] pix_mem0 [MAX_WIDTH];
    logic [7:0] pix_mem1 [MAX_WIDTH];
    logic [7:0] r_rd_p0, r_rd_p1;
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            pix_mem0[r_col] <= r_pix;
        end
        if (i_cmd.read) begin
            r_rd_p0 <= pix_mem0[r_col];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            pix_mem1[r_col] <= r_rd_p0;
        end
        if (i_cmd.read) begin
            r_rd_p1 <= pix_mem1[r_col];
        end
    end

    // gradient line stores: rows r-5 .. r-2 of the gradient image
    logic [CW-1:0] g_addr;
    assign g_addr = r_col - 1'b1;
    logic [21:0] grad_mem [4][MAX_WIDTH];
    logic [21:0] r_rd_g [4];
    logic [21:0] g_wdata [4];
    for (genvar k = 0; k < 4; k++) begin : g_grad_store
        always_ff @(posedge i_clk) begin
            if (i_cmd.grad && r_col != '0) begin
                grad_mem[k][g_addr] <= g_wdata[k];
            end
            if (i_cmd.read) begin
                r_rd_g[k] <= grad_mem[k][g_addr];
            end
        end
    end

    // 3x3 pixel window, index = 3*column + row, column 0 oldest
    logic [7:0] r_win [9];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else if (i_cmd.shift) begin
            for (int k = 0; k < 6; k++) r_win[k] <= r_win[k + 3];
            r_win[6] <= r_rd_p1;
            r_win[7] <= r_rd_p0;
            r_win[8] <= r_pix;
        end
    end

    // Sobel gradients centered one row and one column back
    logic signed [10:0] gx, gy;
    logic signed [10:0] s_d [3];
    logic signed [10:0] s_v [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_d[k] = $signed({3'b0, r_win[3 * k]}) - $signed({3'b0, r_win[3 * k + 2]});
            s_v[k] = $signed({3'b0, r_win[3 * k]}) + $signed({2'b0, r_win[3 * k + 1], 1'b0})
                   + $signed({3'b0, r_win[3 * k + 2]});
        end
        gx = s_d[0] + (s_d[1] <<< 1) + s_d[2];
        gy = s_v[0] - s_v[2];
    end

    always_comb begin
        for (int k = 0; k < 3; k++) g_wdata[k] = r_rd_g[k + 1];
        g_wdata[3] = {gy, gx};
    end

    // gradient column: taps 0..3 from the stores, tap 4 new
    logic signed [10:0] r_cgx [SUM_STEPS];
    logic signed [10:0] r_cgy [SUM_STEPS];
    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            for (int k = 0; k < 4; k++) begin
                r_cgx[k] <= (r_col != '0) ? $signed(r_rd_g[k][10:0])  : '0;
                r_cgy[k] <= (r_col != '0) ? $signed(r_rd_g[k][21:11]) : '0;
            end
            r_cgx[4] <= gx;
            r_cgy[4] <= gy;
        end
    end

    // column products, one tap a cycle
    logic [2:0]         tap;
    logic signed [10:0] tgx, tgy;
    logic signed [21:0] pxx, pyy, pxy;
    assign tap = i_cmd.step[2:0];
    assign tgx = r_cgx[tap];
    assign tgy = r_cgy[tap];
    assign pxx = tgx * tgx;
    assign pyy = tgy * tgy;
    assign pxy = tgx * tgy;

    logic [22:0]        r_cxx, r_cyy;
    logic signed [23:0] r_cxy;
    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_cxx <= '0;
            r_cyy <= '0;
            r_cxy <= '0;
        end else if (i_cmd.col_step) begin
            r_cxx <= r_cxx + 23'($unsigned(pxx));
            r_cyy <= r_cyy + 23'($unsigned(pyy));
            r_cxy <= r_cxy + 24'(pxy);
        end
    end

    // five column sums of the 5x5 window
    logic [22:0]        r_sum_xx [SUM_STEPS];
    logic [22:0]        r_sum_yy [SUM_STEPS];
    logic signed [23:0] r_sum_xy [SUM_STEPS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SUM_STEPS; k++) begin
                r_sum_xx[k] <= '0;
                r_sum_yy[k] <= '0;
                r_sum_xy[k] <= '0;
            end
        end else if (i_cmd.cshift) begin
            for (int k = 0; k < SUM_STEPS - 1; k++) begin
                r_sum_xx[k] <= r_sum_xx[k + 1];
                r_sum_yy[k] <= r_sum_yy[k + 1];
                r_sum_xy[k] <= r_sum_xy[k + 1];
            end
            r_sum_xx[SUM_STEPS - 1] <= r_cxx;
            r_sum_yy[SUM_STEPS - 1] <= r_cyy;
            r_sum_xy[SUM_STEPS - 1] <= r_cxy;
        end
    end

    // window totals, one column a cycle
    logic [24:0]        r_sxx, r_syy;
    logic signed [25:0] r_sxy;
    always_ff @(posedge i_clk) begin
        if (i_cmd.cshift) begin
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
        end else if (i_cmd.wsum_step) begin
            r_sxx <= r_sxx + 25'(r_sum_xx[tap]);
            r_syy <= r_syy + 25'(r_sum_yy[tap]);
            r_sxy <= r_sxy + 26'(r_sum_xy[tap]);
        end
    end

    // magnitudes, trace, then serial square: acc = d^2 + 4*sxy^2
    logic signed [25:0] diff;
    logic [24:0]        r_dmag, r_smag;
    logic [25:0]        r_trace;
    logic [51:0]        r_acc;
    logic [4:0]         bit_i;
    assign diff  = $signed({1'b0, r_sxx}) - $signed({1'b0, r_syy});
    assign bit_i = i_cmd.step;
    always_ff @(posedge i_clk) begin
        if (i_cmd.abs_diff) begin
            r_dmag  <= diff[25] ? 25'(-diff) : diff[24:0];
            r_smag  <= r_sxy[25] ? 25'(-r_sxy) : r_sxy[24:0];
            r_trace <= {1'b0, r_sxx} + {1'b0, r_syy};
            r_acc   <= '0;
        end else if (i_cmd.mul_step) begin
            r_acc <= r_acc
                   + (r_dmag[bit_i] ? (52'(r_dmag) << bit_i) : '0)
                   + (r_smag[bit_i] ? (52'(r_smag) << (bit_i + 3'd2)) : '0);
        end
    end

    // floor square root, one result bit a cycle
    logic [51:0] r_rem, r_root, r_bit, trial;
    assign trial = r_root + r_bit;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_rem  <= r_acc;
            r_root <= '0;
            r_bit  <= 52'd1 << 50;
        end else if (i_cmd.sqrt_step) begin
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // response, thresholded; zero where the support leaves the image
    logic [25:0] half_gap;
    logic [24:0] resp;
    assign half_gap = (r_trace - r_root[25:0]) >> 1;
    always_comb begin
        resp = '0;
        if (o_status.full_window && half_gap[24:0] > r_threshold) begin
            resp = half_gap[24:0];
        end
    end

    // output register
    logic          r_out_valid;
    logic [CW-1:0] out_c;
    logic [RW-1:0] out_r;
    assign out_c = r_col - CW'(3);
    assign out_r = r_row - RW'(3);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_response <= resp;
            o_out_row  <= 12'(out_r);
            o_out_col  <= 10'(out_c);
        end
    end
    assign o_out_valid = r_out_valid;

    // status
    assign o_status.has_result  = (r_row >= RW'(3)) && (r_col >= CW'(3));
    assign o_status.full_window = (r_row >= RW'(6)) && (r_col >= CW'(6));
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

endmodule

// ===== hdl/sobel_min_eigen_corner_response_core.sv =====
// Sobel / 5x5 minimum-eigenvalue corner response core, one pixel item at a time.
// Items with a full window pass through a bit-serial squarer of 25 steps and a square
// root of 26 steps before their result; border items skip both, and items with no
// result only keep the input stalled while in process. A new item is accepted only
// once the last is done and its result loaded. Reset (synchronous, active low) clears
// counters, windows, sums and control; line stores are not cleared. Depends on smecr_pkg.
module sobel_min_eigen_corner_response_core
    import smecr_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_pixel,
    input  logic                  i_frame_start,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [24:0]           o_response,
    output logic [11:0]           o_out_row,
    output logic [9:0]            o_out_col
);

    t_cmd    cmd;
    t_status status;

    smecr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    smecr_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_response    (o_response),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for sobel_min_eigen_corner_response_core.
// Predicts each corner response in-line from the accepted pixel items; needs smecr_pkg.
module tb;
    import smecr_pkg::*;

    localparam int MAXW       = 1024;
    localparam int MAXR       = 4096;
    localparam int SETTLE     = 100;
    localparam int LIMIT      = 4000000;
    localparam int THRESH_MAX = 26010000;

    typedef struct {
        logic [24:0] response;
        logic [11:0] row;
        logic [9:0]  col;
    } corner_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_pixel = '0;
    logic                  i_frame_start = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [24:0]           o_response;
    logic [11:0]           o_out_row;
    logic [9:0]            o_out_col;

    sobel_min_eigen_corner_response_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow state of the block
    int          pix_line [0:2*MAXW-1];
    int          gx_line  [0:4*MAXW-1];
    int          gy_line  [0:4*MAXW-1];
    int          win      [0:8];
    longint      csum_xx  [0:4];
    longint      csum_yy  [0:4];
    longint      csum_xy  [0:4];
    int          row_cnt, col_cnt;
    logic [10:0] width_reg;
    logic [24:0] thresh_reg;

    corner_t     corner_q [$];
    int          errors = 0;
    int          items_in = 0;
    int          results_out = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned x, res, b;
        x = n;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // advance the shadow state by one pixel; returns 1 when a response is due
    function automatic bit corner_predict(input logic [7:0] p, input logic fs,
                                          output corner_t o);
        int w, r, c, gx, gy, g;
        int s [0:2];
        int v [0:2];
        int gxs [0:4];
        int gys [0:4];
        longint cxx, cyy, cxy, sxx, syy, sxy, d;
        longint unsigned disc, root, resp;
        bit has;
        w = width_reg;
        if (w < WIDTH_MIN) w = WIDTH_MIN;
        if (w > MAXW) w = MAXW;
        if (fs) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        if (col_cnt >= w) col_cnt = w - 1;
        r = row_cnt;
        c = col_cnt;
        for (int k = 0; k < 6; k++) win[k] = win[k+3];
        win[6] = pix_line[MAXW + c];
        win[7] = pix_line[c];
        win[8] = p;
        pix_line[MAXW + c] = pix_line[c];
        pix_line[c] = p;
        for (int k = 0; k < 3; k++) begin
            s[k] = win[3*k] - win[3*k+2];
            v[k] = win[3*k] + 2*win[3*k+1] + win[3*k+2];
        end
        gx = s[0] + 2*s[1] + s[2];
        gy = v[0] - v[2];
        if (c >= 1) begin
            g = c - 1;
            for (int k = 0; k < 4; k++) begin
                gxs[k] = gx_line[k*MAXW + g];
                gys[k] = gy_line[k*MAXW + g];
            end
            for (int k = 0; k < 3; k++) begin
                gx_line[k*MAXW + g] = gx_line[(k+1)*MAXW + g];
                gy_line[k*MAXW + g] = gy_line[(k+1)*MAXW + g];
            end
            gx_line[3*MAXW + g] = gx;
            gy_line[3*MAXW + g] = gy;
        end else begin
            for (int k = 0; k < 4; k++) begin
                gxs[k] = 0;
                gys[k] = 0;
            end
        end
        gxs[4] = gx;
        gys[4] = gy;
        cxx = 0; cyy = 0; cxy = 0;
        for (int k = 0; k < 5; k++) begin
            cxx += gxs[k]*gxs[k];
            cyy += gys[k]*gys[k];
            cxy += gxs[k]*gys[k];
        end
        for (int k = 0; k < 4; k++) begin
            csum_xx[k] = csum_xx[k+1];
            csum_yy[k] = csum_yy[k+1];
            csum_xy[k] = csum_xy[k+1];
        end
        csum_xx[4] = cxx;
        csum_yy[4] = cyy;
        csum_xy[4] = cxy;
        has = 1'b0;
        if (r >= 3 && c >= 3) begin
            resp = 0;
            if (r >= 6 && c >= 6) begin
                sxx = 0; syy = 0; sxy = 0;
                for (int k = 0; k < 5; k++) begin
                    sxx += csum_xx[k];
                    syy += csum_yy[k];
                    sxy += csum_xy[k];
                end
                d = sxx - syy;
                if (d < 0) d = -d;
                if (sxy < 0) sxy = -sxy;
                disc = d*d + 4*sxy*sxy;
                root = isqrt(disc);
                resp = (longint'(sxx + syy) - root) >> 1;
                if (resp <= thresh_reg) resp = 0;
            end
            o.response = resp[24:0];
            o.row = 12'(r - 3);
            o.col = 10'(c - 3);
            has = 1'b1;
        end
        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            if (row_cnt < MAXR - 1) row_cnt++;
        end
        return has;
    endfunction

    // accepted pixel items feed the shadow model
    always @(posedge i_clk) begin
        corner_t e;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            items_in++;
            if (corner_predict(i_pixel, i_frame_start, e)) corner_q.push_back(e);
        end
    end

    // compare each accepted result with the oldest expected one
    always @(posedge i_clk) begin
        corner_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_out++;
            if (corner_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result resp=%0d row=%0d col=%0d",
                                           o_response, o_out_row, o_out_col);
            end else begin
                e = corner_q.pop_front();
                if (o_response !== e.response || o_out_row !== e.row
                        || o_out_col !== e.col) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp resp=%0d row=%0d col=%0d got %0d %0d %0d",
                                 e.response, e.row, e.col, o_response, o_out_row, o_out_col);
                end
            end
        end
    end

    // receiver stalls in bursts of random length, started at random
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: done, errors");
            $finish;
        end
    end

    // one pixel item, with an optional idle burst ahead of it
    task automatic send_pixel(input logic [7:0] p, input logic fs);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_pixel       <= p;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drain results, then allow for items still in flight that give none
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (corner_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_reg = data[10:0];
        else thresh_reg = data[24:0];
    endtask

    // pixel value by pattern: 0 random, 1 black/white, 2 checkerboard, 3 ramp
    function automatic logic [7:0] pattern_pixel(int mode, int r, int c);
        case (mode)
            0: return 8'($urandom);
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: return ((r + c) % 2) ? 8'hFF : 8'h00;
            default: return 8'((r * 37 + c * 11) & 8'hFF);
        endcase
    endfunction

    task automatic send_frame(input int w, input int rows, input int mode, input bit noise);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < w; c++) begin
                send_pixel(pattern_pixel(mode, r, c),
                           (r == 0 && c == 0) || (noise && $urandom_range(0, 60) == 0));
            end
        end
    endtask

    // extremes of pixel and a frame start in the middle of a row
    task automatic test_directed();
        write_reg(REG_IMAGE_WIDTH, 25'd3);
        write_reg(REG_THRESHOLD, 25'd0);
        for (int i = 0; i < 22; i++)
            send_pixel((i % 3 == 0) ? 8'hFF : 8'h00, i == 0 || i == 13);
        settle();
    endtask

    // small frames, varied width, threshold and content
    task automatic test_random_frames(input int count);
        int w, rows, sel;
        logic [CFG_DATA_W-1:0] th;
        for (int f = 0; f < count; f++) begin
            w = $urandom_range(8, 14);
            rows = $urandom_range(7, 10);
            sel = $urandom_range(0, 5);
            if (sel == 0) th = '0;
            else if (sel == 1) th = CFG_DATA_W'(THRESH_MAX);
            else if (sel == 2) th = CFG_DATA_W'($urandom_range(0, 200000));
            else th = CFG_DATA_W'($urandom_range(0, THRESH_MAX));
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'({$urandom} & 32'h1FFF800 | 32'(w)));
            write_reg(REG_THRESHOLD, th);
            send_frame(w, rows, $urandom_range(0, 3), $urandom_range(0, 4) == 0);
            settle();
        end
    endtask

    // width 0 acts as the minimum, all ones as the maximum
    task automatic test_width_extremes();
        write_reg(REG_IMAGE_WIDTH, 25'd0);
        write_reg(REG_THRESHOLD, 25'd0);
        send_frame(8, 8, 2, 1'b0);
        settle();
        write_reg(REG_IMAGE_WIDTH, 25'h7FF);
        send_frame(MAXW, 1, 0, 1'b0);
        for (int c = 0; c < 20; c++) send_pixel(8'($urandom), 1'b0);
        settle();
    endtask

    // one frame with no idling on either side, from here to the end
    task automatic test_no_idle();
        quiet = 1'b1;
        write_reg(REG_IMAGE_WIDTH, 25'd8);
        write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 50000)));
        send_frame(8, 8, 0, 1'b0);
        settle();
    endtask

    initial begin
        for (int i = 0; i < 2*MAXW; i++) pix_line[i] = 0;
        for (int i = 0; i < 4*MAXW; i++) begin
            gx_line[i] = 0;
            gy_line[i] = 0;
        end
        for (int i = 0; i < 9; i++) win[i] = 0;
        for (int i = 0; i < 5; i++) begin
            csum_xx[i] = 0;
            csum_yy[i] = 0;
            csum_xy[i] = 0;
        end
        row_cnt = 0;
        col_cnt = 0;
        width_reg = 11'(WIDTH_RESET);
        thresh_reg = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_frames(8);
        test_width_extremes();
        test_no_idle();
        $display("covered %0d pixel items and %0d responses in %0d cycles",
                 items_in, results_out, cycles);
        $display("frames of width 8 to 1024, thresholds 0 to max, mid-row frame starts");
        if (errors == 0 && corner_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d expected left", errors, corner_q.size());
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/smecr_pkg.sv
hdl/smecr_ctrl.sv
hdl/smecr_datapath.sv
hdl/sobel_min_eigen_corner_response_core.sv
verif/tb.sv
